// ----- rtl/vfc_pkg.sv -----
// Shared types and constants for the varint frame classifier.
// Used by every module in rtl/; depends on nothing else.
`default_nettype none

package vfc_pkg;

    // Default and largest number of bytes in one varint field
    localparam int unsigned MAX_VARINT_BYTES_DEF = 5;

    // Field widths
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned SIZE_W  = 3;

    // Byte layout of a varint byte
    localparam int unsigned CONT_BIT = 7;
    localparam logic [6:0]  DATA_MASK = 7'h7f;

    // Id value that switches a flow to compressed framing
    localparam logic [VALUE_W-1:0] ID_SWITCH = 32'h0000_0003;

    // Largest number of bytes counted in one packet
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = 16'hffff;

    // One input word
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       byte_present;
        logic       last_byte;
        logic       is_tcp;
        logic       flow_compressed_in;
    } t_in_word;

    // One result word
    typedef struct packed {
        logic is_match;
        logic flow_compressed_out;
    } t_out_word;

endpackage

`default_nettype wire

// ----- rtl/varint_frame_classifier.sv -----
// Top level of the varint frame classifier: input register, parser, result register.
// Depends on vfc_pkg, vfc_in_stage and vfc_parser.
//
// Usage:
//   The input channel (i_in_valid / o_in_ready / i_in_word) carries one payload
//   word per handshake; last_byte closes a packet. Words with byte_present low
//   carry no byte; is_tcp and flow_compressed_in are taken from a packet's first
//   word. The output channel (o_out_valid / i_out_ready / o_out_word) carries
//   one result word per packet, made from the packet's last word.
//   Timing: the last word is captured in the input register and is judged on
//   its way into the result register, which raises o_out_valid and holds the
//   result until i_out_ready takes it. Throughput: one word per cycle unless a
//   packet end waits on a busy result register; the parser updates its varint
//   state as each word is taken, so packets may follow each other directly.
//   When the receiver stalls, the result register holds its word; words that do
//   not end a packet keep flowing, and a packet end waits in the input register
//   until the result register frees, holding o_in_ready low meanwhile.
//   Reset (synchronous, active low) empties both registers and returns the
//   parser to the start of a packet.
`default_nettype none

module varint_frame_classifier #(
    parameter int unsigned MAX_VARINT_BYTES = vfc_pkg::MAX_VARINT_BYTES_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  vfc_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output vfc_pkg::t_out_word  o_out_word
);

    logic               stage_valid;
    vfc_pkg::t_in_word  stage_word;
    logic               proc_fire;
    vfc_pkg::t_out_word result;
    logic               r_out_valid;
    vfc_pkg::t_out_word r_out_word;

    // Consume the held word unless it ends a packet and the result slot is busy
    assign proc_fire = stage_valid
                       && (!stage_word.last_byte || !r_out_valid || i_out_ready);

    vfc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_word  (i_in_word),
        .i_take  (proc_fire),
        .o_valid (stage_valid),
        .o_word  (stage_word)
    );

    vfc_parser #(
        .MAX_VARINT_BYTES (MAX_VARINT_BYTES)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (proc_fire),
        .i_word   (stage_word),
        .o_result (result)
    );

    // Hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire && stage_word.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && stage_word.last_byte) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // A packet end always lands in the result register
    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire && stage_word.last_byte |=> o_out_valid)
        else $error("packet end produced no result");

    // A word that does not end a packet never creates a result
    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire && !stage_word.last_byte && !(r_out_valid && !i_out_ready)
        |=> !o_out_valid)
        else $error("result without packet end");

    // An accepted word is captured into the input register
    a_word_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> stage_valid)
        else $error("accepted word lost");

endmodule

`default_nettype wire

// ----- rtl/vfc_in_stage.sv -----
// Input register of the varint frame classifier: holds one word for the parser.
// Depends on vfc_pkg.
`default_nettype none

module vfc_in_stage (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  vfc_pkg::t_in_word   i_word,
    input  wire                 i_take,
    output logic                o_valid,
    output vfc_pkg::t_in_word   o_word
);

    logic              r_valid;
    vfc_pkg::t_in_word r_word;

    // Accept a new word when empty or when the held word leaves this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/vfc_parser.sv -----
// Per-packet varint parser and frame verdict of the varint frame classifier.
// Depends on vfc_pkg.
`default_nettype none

module vfc_parser #(
    parameter int unsigned MAX_VARINT_BYTES = vfc_pkg::MAX_VARINT_BYTES_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_fire,
    input  vfc_pkg::t_in_word   i_word,
    output vfc_pkg::t_out_word  o_result
);

    typedef enum logic [1:0] {
        PH_LEN,
        PH_ID,
        PH_BODY
    } t_phase;

    localparam logic [vfc_pkg::SIZE_W-1:0] MaxIdx = vfc_pkg::SIZE_W'(MAX_VARINT_BYTES);

    t_phase                         r_phase,  n_phase;
    logic [vfc_pkg::VALUE_W-1:0]    r_acc,    n_acc;
    logic [vfc_pkg::SIZE_W-1:0]     r_idx,    n_idx;
    logic [vfc_pkg::VALUE_W-1:0]    r_len,    n_len;
    logic [vfc_pkg::SIZE_W-1:0]     r_lsize,  n_lsize;
    logic [vfc_pkg::VALUE_W-1:0]    r_id,     n_id;
    logic [vfc_pkg::SIZE_W-1:0]     r_isize,  n_isize;
    logic [vfc_pkg::COUNT_W-1:0]    r_count,  n_count;
    logic                           r_failed, n_failed;
    logic                           r_tcp,    n_tcp;
    logic                           r_comp,   n_comp;
    logic                           r_in_pkt;

    logic [5:0]                     shift_amt;
    logic [vfc_pkg::VALUE_W-1:0]    part;
    logic [vfc_pkg::VALUE_W-1:0]    acc_sum;
    logic [vfc_pkg::SIZE_W-1:0]     idx_inc;
    logic [vfc_pkg::SIZE_W:0]       hdr_size;
    logic [vfc_pkg::VALUE_W:0]      frame_len;
    logic                           shape_ok;
    logic                           len_ok;
    logic                           match;

    // Place the seven data bits at 7 * index; bits above 31 drop
    assign shift_amt = 6'({r_idx, 3'b000}) - 6'(r_idx);
    assign part      = vfc_pkg::VALUE_W'(i_word.payload_byte[6:0] & vfc_pkg::DATA_MASK)
                       << shift_amt;
    assign acc_sum   = r_acc | part;
    assign idx_inc   = r_idx + 1'b1;

    // Advance the parse by one byte
    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_idx    = r_idx;
        n_len    = r_len;
        n_lsize  = r_lsize;
        n_id     = r_id;
        n_isize  = r_isize;
        n_count  = r_count;
        n_failed = r_failed;
        n_tcp    = r_in_pkt ? r_tcp  : i_word.is_tcp;
        n_comp   = r_in_pkt ? r_comp : i_word.flow_compressed_in;

        if (i_word.byte_present && !r_failed) begin
            if (r_count == vfc_pkg::COUNT_LIMIT) begin
                n_failed = 1'b1;
            end else begin
                n_count = r_count + 1'b1;
                if (r_phase != PH_BODY) begin
                    n_acc = acc_sum;
                    n_idx = idx_inc;
                    if (!i_word.payload_byte[vfc_pkg::CONT_BIT]) begin
                        if (acc_sum[vfc_pkg::VALUE_W-1]) begin
                            n_failed = 1'b1;
                        end else begin
                            if (r_phase == PH_LEN) begin
                                n_len   = acc_sum;
                                n_lsize = idx_inc;
                                n_phase = PH_ID;
                            end else begin
                                n_id    = acc_sum;
                                n_isize = idx_inc;
                                n_phase = PH_BODY;
                            end
                            n_acc = '0;
                            n_idx = '0;
                        end
                    end else if (idx_inc >= MaxIdx) begin
                        n_failed = 1'b1;
                    end
                end
            end
        end
    end

    // Judge the frame from the state after this byte
    assign hdr_size  = {1'b0, n_lsize} + {1'b0, n_isize};
    assign frame_len = {1'b0, n_len} + (vfc_pkg::VALUE_W+1)'(n_lsize);
    assign shape_ok  = n_tcp && !n_failed && (n_phase == PH_BODY)
                       && (n_count > vfc_pkg::COUNT_W'(hdr_size));
    assign len_ok    = frame_len == (vfc_pkg::VALUE_W+1)'(n_count);
    assign match     = shape_ok && len_ok && (!n_comp || (n_id == '0));

    assign o_result.is_match            = match;
    assign o_result.flow_compressed_out = n_comp
                                          || (match && (n_id == vfc_pkg::ID_SWITCH));

    // Hold parse state; clear it at the end of each packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_word.last_byte)) begin
            r_phase  <= PH_LEN;
            r_acc    <= '0;
            r_idx    <= '0;
            r_len    <= '0;
            r_lsize  <= '0;
            r_id     <= '0;
            r_isize  <= '0;
            r_count  <= '0;
            r_failed <= 1'b0;
            r_tcp    <= 1'b0;
            r_comp   <= 1'b0;
            r_in_pkt <= 1'b0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_idx    <= n_idx;
            r_len    <= n_len;
            r_lsize  <= n_lsize;
            r_id     <= n_id;
            r_isize  <= n_isize;
            r_count  <= n_count;
            r_failed <= n_failed;
            r_tcp    <= n_tcp;
            r_comp   <= n_comp;
            r_in_pkt <= 1'b1;
        end
    end

endmodule

`default_nettype wire
